@@ rtl/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle circumcenter package
// Widths, pipeline payload types and the divider step shared by the
// circumcenter datapath.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Field widths.
    localparam int COORD_W = 16;          // vertex coordinate
    localparam int OUT_W   = 32;          // center coordinate

    // Internal widths, sized for exact intermediate values.
    localparam int DIFF_W  = COORD_W + 1; // edge vector component
    localparam int PROD_W  = 2 * DIFF_W;  // product of a pair of edge components
    localparam int SQ_W    = PROD_W;      // squared edge length
    localparam int D_W     = PROD_W + 2;  // twice the cross product
    localparam int DEN_W   = D_W;         // divisor 2*|D|
    localparam int NP_W    = DIFF_W + SQ_W;   // component times squared length
    localparam int N_W     = NP_W + 1;        // numerator before rounding
    localparam int NUM_W   = N_W + 1;         // dividend 2*|N| + |D|
    localparam int DIV_STAGES = NUM_W;        // one quotient bit per stage
    localparam int NEAR_BITS  = 40;           // quotients at or above 2^40 clamp
    localparam int SUM_W      = NEAR_BITS + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 42'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -42'sd2147483648;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_tri;

    // Per-item information that rides alongside the divider.
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      degen;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_in;

    typedef struct packed {
        logic [NUM_W-1:0] q_x;
        logic [NUM_W-1:0] q_y;
        t_side            side;
    } t_div_out;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
    } t_dstep;

    // One restoring division step.
    function automatic t_dstep div_step(input logic [DEN_W-1:0] rem,
                                        input logic [NUM_W-1:0] nq,
                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        t_dstep         r;
        trial = {rem, nq[NUM_W-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            r.rem = diff[DEN_W-1:0];
            r.nq  = {nq[NUM_W-2:0], 1'b1};
        end else begin
            r.rem = trial[DEN_W-1:0];
            r.nq  = {nq[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/tcc_if.sv @@
// ----------------------------------------------------------------------------
// Triangle circumcenter channels
// Valid/ready channels for triangles in and centers out.
// ----------------------------------------------------------------------------
interface tcc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                    vertex_c_x, vertex_c_y, input ready);
    modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                    vertex_c_x, vertex_c_y, output ready);
endinterface

interface tcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               degenerate;
    logic               saturated;

    modport source (output valid, center_x, center_y, degenerate, saturated,
                    input ready);
    modport sink   (input valid, center_x, center_y, degenerate, saturated,
                    output ready);
endinterface

@@ rtl/tcc_geom.sv @@
// ----------------------------------------------------------------------------
// Circumcenter geometry front end
// Five register stages: edge vectors, products, lengths and determinant,
// numerator products, and the rounded dividend and divisor.
// ----------------------------------------------------------------------------
module tcc_geom (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  tcc_pkg::t_tri    i_tri,
    output logic             o_valid,
    output tcc_pkg::t_div_in o_div
);
    import tcc_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [DIFF_W-1:0]  bx;
        logic signed [DIFF_W-1:0]  by;
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
    } t_s1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [DIFF_W-1:0]  bx;
        logic signed [DIFF_W-1:0]  by;
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
        logic signed [PROD_W-1:0]  sq_bx;
        logic signed [PROD_W-1:0]  sq_by;
        logic signed [PROD_W-1:0]  sq_cx;
        logic signed [PROD_W-1:0]  sq_cy;
        logic signed [PROD_W-1:0]  cr1;
        logic signed [PROD_W-1:0]  cr2;
    } t_s2;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [DIFF_W-1:0]  bx;
        logic signed [DIFF_W-1:0]  by;
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
        logic [SQ_W-1:0]           lb;
        logic [SQ_W-1:0]           lc;
        logic signed [D_W-1:0]     d;
    } t_s3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [NP_W-1:0]    px1;
        logic signed [NP_W-1:0]    px2;
        logic signed [NP_W-1:0]    py1;
        logic signed [NP_W-1:0]    py2;
        logic signed [D_W-1:0]     d;
    } t_s4;

    logic [4:0] r_v;
    t_s1     r_s1, n_s1;
    t_s2     r_s2, n_s2;
    t_s3     r_s3, n_s3;
    t_s4     r_s4, n_s4;
    t_div_in r_s5, n_s5;

    logic signed [N_W-1:0]  nx, ny;
    logic [N_W-1:0]         abs_nx, abs_ny;
    logic [D_W-1:0]         abs_d;

    // Stage 1: edge vectors relative to vertex A.
    always_comb begin
        n_s1.ax = i_tri.ax;
        n_s1.ay = i_tri.ay;
        n_s1.bx = DIFF_W'(i_tri.bx) - DIFF_W'(i_tri.ax);
        n_s1.by = DIFF_W'(i_tri.by) - DIFF_W'(i_tri.ay);
        n_s1.cx = DIFF_W'(i_tri.cx) - DIFF_W'(i_tri.ax);
        n_s1.cy = DIFF_W'(i_tri.cy) - DIFF_W'(i_tri.ay);
    end

    // Stage 2: squares and cross terms.
    always_comb begin
        n_s2.ax    = r_s1.ax;
        n_s2.ay    = r_s1.ay;
        n_s2.bx    = r_s1.bx;
        n_s2.by    = r_s1.by;
        n_s2.cx    = r_s1.cx;
        n_s2.cy    = r_s1.cy;
        n_s2.sq_bx = PROD_W'(r_s1.bx) * PROD_W'(r_s1.bx);
        n_s2.sq_by = PROD_W'(r_s1.by) * PROD_W'(r_s1.by);
        n_s2.sq_cx = PROD_W'(r_s1.cx) * PROD_W'(r_s1.cx);
        n_s2.sq_cy = PROD_W'(r_s1.cy) * PROD_W'(r_s1.cy);
        n_s2.cr1   = PROD_W'(r_s1.bx) * PROD_W'(r_s1.cy);
        n_s2.cr2   = PROD_W'(r_s1.by) * PROD_W'(r_s1.cx);
    end

    // Stage 3: squared edge lengths and the determinant D.
    always_comb begin
        n_s3.ax = r_s2.ax;
        n_s3.ay = r_s2.ay;
        n_s3.bx = r_s2.bx;
        n_s3.by = r_s2.by;
        n_s3.cx = r_s2.cx;
        n_s3.cy = r_s2.cy;
        n_s3.lb = SQ_W'(unsigned'(r_s2.sq_bx)) + SQ_W'(unsigned'(r_s2.sq_by));
        n_s3.lc = SQ_W'(unsigned'(r_s2.sq_cx)) + SQ_W'(unsigned'(r_s2.sq_cy));
        n_s3.d  = (D_W'(r_s2.cr1) - D_W'(r_s2.cr2)) <<< 1;
    end

    // Stage 4: numerator products.
    always_comb begin
        n_s4.ax  = r_s3.ax;
        n_s4.ay  = r_s3.ay;
        n_s4.d   = r_s3.d;
        n_s4.px1 = NP_W'(r_s3.cy) * NP_W'(signed'({1'b0, r_s3.lb}));
        n_s4.px2 = NP_W'(r_s3.by) * NP_W'(signed'({1'b0, r_s3.lc}));
        n_s4.py1 = NP_W'(r_s3.bx) * NP_W'(signed'({1'b0, r_s3.lc}));
        n_s4.py2 = NP_W'(r_s3.cx) * NP_W'(signed'({1'b0, r_s3.lb}));
    end

    // Stage 5: signs, magnitudes and the round-half-away dividend.
    always_comb begin
        nx     = N_W'(r_s4.px1) - N_W'(r_s4.px2);
        ny     = N_W'(r_s4.py1) - N_W'(r_s4.py2);
        abs_nx = nx[N_W-1] ? N_W'(-nx) : N_W'(nx);
        abs_ny = ny[N_W-1] ? N_W'(-ny) : N_W'(ny);
        abs_d  = r_s4.d[D_W-1] ? D_W'(-r_s4.d) : D_W'(r_s4.d);
        n_s5.num_x       = (NUM_W'(abs_nx) << 1) + NUM_W'(abs_d);
        n_s5.num_y       = (NUM_W'(abs_ny) << 1) + NUM_W'(abs_d);
        n_s5.den         = DEN_W'(abs_d) << 1;
        n_s5.side.base_x = r_s4.ax;
        n_s5.side.base_y = r_s4.ay;
        n_s5.side.neg_x  = nx[N_W-1] ^ r_s4.d[D_W-1];
        n_s5.side.neg_y  = ny[N_W-1] ^ r_s4.d[D_W-1];
        n_s5.side.degen  = (r_s4.d == '0);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    assign o_valid = r_v[4];
    assign o_div   = r_s5;
endmodule

@@ rtl/tcc_div.sv @@
// ----------------------------------------------------------------------------
// Circumcenter divider pipeline
// Two restoring dividers in lockstep, one quotient bit per register stage,
// sharing one divisor and carrying the item's side information.
// ----------------------------------------------------------------------------
module tcc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tcc_pkg::t_div_in  i_div,
    output logic              o_valid,
    output tcc_pkg::t_div_out o_div
);
    import tcc_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem_x;
        logic [NUM_W-1:0] nq_x;
        logic [DEN_W-1:0] rem_y;
        logic [NUM_W-1:0] nq_y;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_stg;

    logic [DIV_STAGES-1:0] r_vld;
    t_stg r_stg [DIV_STAGES];
    t_stg n_stg [DIV_STAGES];
    t_stg stg_in [DIV_STAGES];

    // Each stage takes one step on the previous stage's contents; stage 0 steps on the input.
    always_comb begin
        t_dstep sx;
        t_dstep sy;
        stg_in[0].rem_x = '0;
        stg_in[0].nq_x  = i_div.num_x;
        stg_in[0].rem_y = '0;
        stg_in[0].nq_y  = i_div.num_y;
        stg_in[0].den   = i_div.den;
        stg_in[0].side  = i_div.side;
        for (int k = 1; k < DIV_STAGES; k++) begin
            stg_in[k] = r_stg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            sx = div_step(stg_in[k].rem_x, stg_in[k].nq_x, stg_in[k].den);
            sy = div_step(stg_in[k].rem_y, stg_in[k].nq_y, stg_in[k].den);
            n_stg[k].rem_x = sx.rem;
            n_stg[k].nq_x  = sx.nq;
            n_stg[k].rem_y = sy.rem;
            n_stg[k].nq_y  = sy.nq;
            n_stg[k].den   = stg_in[k].den;
            n_stg[k].side  = stg_in[k].side;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid    = r_vld[DIV_STAGES-1];
    assign o_div.q_x  = r_stg[DIV_STAGES-1].nq_x;
    assign o_div.q_y  = r_stg[DIV_STAGES-1].nq_y;
    assign o_div.side = r_stg[DIV_STAGES-1].side;
endmodule

@@ rtl/triangle_circumcenter_top.sv @@
// ----------------------------------------------------------------------------
// Triangle circumcenter, top level
// Streams triangles in and returns the rounded, clamped circumcenter.
//
//   Channel  Direction  Payload
//   i_in     sink       vertex_a_x/y, vertex_b_x/y, vertex_c_x/y (16 b signed)
//   o_out    source     center_x/y (32 b signed), degenerate, saturated
//
// One triangle is accepted per cycle while the pipeline advances. The path runs through
// five geometry stages, 53 divider stages (one quotient bit each) and one output register.
// Reset clears all valid bits.
// When a result waits untaken, the whole pipeline holds and i_in.ready drops.
// ----------------------------------------------------------------------------
module triangle_circumcenter_top (
    input  logic i_clk,
    input  logic i_rst_n,
    tcc_in_if.sink    i_in,
    tcc_out_if.source o_out
);
    import tcc_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] val;
        logic                    sat;
    } t_place;

    logic     adv;
    t_tri     tri_in;
    logic     geom_valid;
    t_div_in  geom_div;
    logic     div_valid;
    t_div_out div_res;
    t_place   pl_x, pl_y;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_cx, n_cx;
    logic signed [OUT_W-1:0] r_cy, n_cy;
    logic                    r_degen, n_degen;
    logic                    r_sat, n_sat;

    // Base plus signed rounded quotient, clamped to the output range.
    function automatic t_place place(input logic signed [COORD_W-1:0] base,
                                     input logic [NUM_W-1:0] q,
                                     input logic neg);
        logic signed [SUM_W-1:0] mag;
        logic signed [SUM_W-1:0] v;
        t_place                  r;
        mag = signed'(SUM_W'(q[NEAR_BITS-1:0]));
        v   = neg ? SUM_W'(base) - mag : SUM_W'(base) + mag;
        if (|q[NUM_W-1:NEAR_BITS]) begin
            r.val = neg ? OUT_W'(SUM_MIN) : OUT_W'(SUM_MAX);
            r.sat = 1'b1;
        end else if (v > SUM_MAX) begin
            r.val = OUT_W'(SUM_MAX);
            r.sat = 1'b1;
        end else if (v < SUM_MIN) begin
            r.val = OUT_W'(SUM_MIN);
            r.sat = 1'b1;
        end else begin
            r.val = OUT_W'(v);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // The pipeline moves whenever the output register is free or drained.
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = adv;

    assign tri_in.ax = i_in.vertex_a_x;
    assign tri_in.ay = i_in.vertex_a_y;
    assign tri_in.bx = i_in.vertex_b_x;
    assign tri_in.by = i_in.vertex_b_y;
    assign tri_in.cx = i_in.vertex_c_x;
    assign tri_in.cy = i_in.vertex_c_y;

    tcc_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in.valid),
        .i_tri   (tri_in),
        .o_valid (geom_valid),
        .o_div   (geom_div)
    );

    tcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (geom_valid),
        .i_div   (geom_div),
        .o_valid (div_valid),
        .o_div   (div_res)
    );

    // Final placement and the collinear case.
    always_comb begin
        pl_x = place(div_res.side.base_x, div_res.q_x, div_res.side.neg_x);
        pl_y = place(div_res.side.base_y, div_res.q_y, div_res.side.neg_y);
        if (div_res.side.degen) begin
            n_cx    = '0;
            n_cy    = '0;
            n_degen = 1'b1;
            n_sat   = 1'b0;
        end else begin
            n_cx    = pl_x.val;
            n_cy    = pl_y.val;
            n_degen = 1'b0;
            n_sat   = pl_x.sat | pl_y.sat;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= div_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_degen <= n_degen;
            r_sat   <= n_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.center_x   = r_cx;
    assign o_out.center_y   = r_cy;
    assign o_out.degenerate = r_degen;
    assign o_out.saturated  = r_sat;
endmodule
